// File: design/fasr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fasr_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_IDLE_GAP  = 2'd0;
	localparam logic [1:0] CFG_ERR_OFS   = 2'd1;
	localparam logic [1:0] CFG_STEP_MAX  = 2'd2;
	localparam logic [1:0] CFG_DELAY_MAX = 2'd3;

	// Register reset values
	localparam logic [7:0]  IDLE_GAP_RST  = 8'd15;
	localparam logic [7:0]  ERR_OFS_RST   = 8'd100;
	localparam logic [6:0]  STEP_MAX_RST  = 7'd100;
	localparam logic [14:0] DELAY_MAX_RST = 15'd20000;

	// Per-channel store reset values
	localparam logic [6:0]  STEP_RST  = 7'd10;
	localparam logic [14:0] DELAY_RST = 15'd20000;

	// Frame header length and channel number width (up to eight channels)
	localparam int unsigned HDR_LEN = 3;
	localparam int unsigned CH_NUM_W = 3;

	typedef struct packed {
		logic                hit;  // item is a channel byte, yields a result
		logic [CH_NUM_W-1:0] ch;   // zero-based channel of that byte
	} sync_t;

	typedef struct packed {
		logic [1:0]  channel;
		logic [14:0] delay_value;
		logic [6:0]  step_size;
		logic        direction_up;
	} res_t;

	function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0:    b = 8'h66;
			2'd1:    b = 8'h06;
			2'd2:    b = 8'h60;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// File: design/fasr_frame.sv
`timescale 1ns / 1ps
`default_nettype none

module fasr_frame #(
	parameter int unsigned NUM_CHANNELS = 3
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic         action,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         rx_error,
	input  wire logic [7:0]   idle_gap,
	output fasr_pkg::sync_t   sync
);

	localparam int unsigned FRAME_LEN = fasr_pkg::HDR_LEN + NUM_CHANNELS;
	localparam int unsigned FP_W = $clog2(FRAME_LEN);

	logic [7:0]      idle_q;
	logic            armed_q;
	logic [FP_W-1:0] pos_q;

	logic [7:0]      idle_inc;
	logic            good_byte;
	logic            in_hdr;
	logic            hdr_ok;
	logic [FP_W-1:0] ch_full;
	logic [FP_W-1:0] pos_inc;
	logic            last_ch;

	assign idle_inc  = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
	assign good_byte = !action && !rx_error;
	assign in_hdr    = pos_q < FP_W'(fasr_pkg::HDR_LEN);
	assign hdr_ok    = rx_byte == fasr_pkg::hdr_byte(pos_q[1:0]);
	assign ch_full   = pos_q - FP_W'(fasr_pkg::HDR_LEN);
	assign pos_inc   = pos_q + FP_W'(1);
	assign last_ch   = pos_q == FP_W'(FRAME_LEN - 1);

	always_comb begin
		sync.hit = good_byte && armed_q && !in_hdr;
		sync.ch  = fasr_pkg::CH_NUM_W'(ch_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q  <= '0;
			armed_q <= 1'b0;
			pos_q   <= '0;
		end else if (go) begin
			if (action) begin
				idle_q <= idle_inc;
				if (idle_inc > idle_gap) begin
					armed_q <= 1'b1;
					pos_q   <= '0;
				end
			end else if (!rx_error) begin
				idle_q <= '0;
				if (armed_q) begin
					if ((in_hdr && !hdr_ok) || (!in_hdr && last_ch)) begin
						armed_q <= 1'b0;
						pos_q   <= '0;
					end else begin
						pos_q <= pos_inc;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: design/fasr_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module fasr_chan #(
	parameter int unsigned NUM_CHANNELS = 3
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            upd,
	input  wire fasr_pkg::sync_t sync,
	input  wire logic [7:0]      rx_byte,
	input  wire logic [7:0]      err_ofs,
	input  wire logic [6:0]      step_max,
	input  wire logic [14:0]     delay_max,
	output fasr_pkg::res_t       res
);

	localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [6:0]  step_q  [NUM_CHANNELS];
	logic        dir_q   [NUM_CHANNELS];
	logic [14:0] delay_q [NUM_CHANNELS];

	logic [CH_W-1:0]    idx;
	logic [6:0]         step_cur;
	logic               dir_cur;
	logic [14:0]        delay_cur;
	logic signed [8:0]  err;
	logic               err_pos;
	logic               err_neg;
	logic [6:0]         smax;
	logic [14:0]        dmax;
	logic [7:0]         step_dbl;
	logic [6:0]         step_hlv;
	logic [6:0]         step_new;
	logic signed [16:0] prod;
	logic signed [17:0] sum;
	logic [14:0]        delay_new;
	logic               dir_new;

	assign idx       = sync.ch[CH_W-1:0];
	assign step_cur  = step_q[idx];
	assign dir_cur   = dir_q[idx];
	assign delay_cur = delay_q[idx];

	assign err     = $signed({1'b0, rx_byte}) - $signed({1'b0, err_ofs});
	assign err_neg = err[8];
	assign err_pos = !err[8] && (err != 9'sd0);
	assign smax    = (step_max == 7'd0) ? 7'd1 : step_max;
	assign dmax    = (delay_max == 15'd0) ? 15'd1 : delay_max;

	// Same sign as last move: double up to the cap; opposite sign: halve to a floor of one
	assign step_dbl = {step_cur, 1'b0};
	assign step_hlv = (step_cur[6:1] == 6'd0) ? 7'd1 : {1'b0, step_cur[6:1]};

	always_comb begin
		if ((dir_cur && err_pos) || (!dir_cur && err_neg)) begin
			step_new = (step_dbl > {1'b0, smax}) ? smax : step_dbl[6:0];
		end else if (err_pos || err_neg) begin
			step_new = step_hlv;
		end else begin
			step_new = step_cur;
		end
	end

	assign prod = $signed({1'b0, step_new}) * err;
	assign sum  = $signed({3'b000, delay_cur}) + $signed({prod[16], prod});

	always_comb begin
		if (sum < 18'sd1) begin
			delay_new = 15'd1;
		end else if (sum > $signed({3'b000, dmax})) begin
			delay_new = dmax;
		end else begin
			delay_new = sum[14:0];
		end
	end

	assign dir_new = err_pos ? 1'b1 : (err_neg ? 1'b0 : dir_cur);

	always_comb begin
		res.channel      = sync.ch[1:0] + 2'd1;
		res.delay_value  = delay_new;
		res.step_size    = step_new;
		res.direction_up = dir_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				step_q[i]  <= fasr_pkg::STEP_RST;
				dir_q[i]   <= 1'b0;
				delay_q[i] <= fasr_pkg::DELAY_RST;
			end
		end else if (upd) begin
			step_q[idx]  <= step_new;
			dir_q[idx]   <= dir_new;
			delay_q[idx] <= delay_new;
		end
	end

endmodule

`default_nettype wire

// File: design/framed_adaptive_step_regulator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Payload
// -------  ---------------------  ------------------------------------------------
// in       in_valid / in_ready    action, rx_byte, rx_error
// out      out_valid / out_ready  channel, delay_value, step_size, direction_up
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (low bits per register)
//
// One item per cycle sustained while results are taken. An accepted item lands in
// the input register and resolves there once unblocked; a channel byte shows its
// result in the cycle after it resolves. Reset clears frame sync and idle count and
// presets the registers and channel stores. Ticks and non-channel bytes never
// stall; a channel byte waits in the input register only while the result
// register holds an untaken result.

module framed_adaptive_step_regulator #(
	parameter int unsigned NUM_CHANNELS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output wire logic        in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        rx_error,
	output wire logic        out_valid,
	input  wire logic        out_ready,
	output wire logic [1:0]  channel,
	output wire logic [14:0] delay_value,
	output wire logic [6:0]  step_size,
	output wire logic        direction_up,
	input  wire logic        cfg_valid,
	output wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data
);

	// Configuration registers
	logic [7:0]  idle_gap_q;
	logic [7:0]  err_ofs_q;
	logic [6:0]  step_max_q;
	logic [14:0] delay_max_q;

	// Input register
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  rx_byte_s1;
	logic        rx_error_s1;

	// Result register
	logic            out_valid_q;
	fasr_pkg::res_t  out_q;

	fasr_pkg::sync_t sync;
	fasr_pkg::res_t  res;
	logic            out_free;
	logic            go;
	logic            take;

	// The result slot frees when empty or when its result transfers this cycle
	assign out_free = !out_valid_q || out_ready;
	// Resolve the held item unless it needs the result slot and the slot is busy
	assign go       = valid_s1 && (!sync.hit || out_free);
	assign take     = !valid_s1 || go;
	assign in_ready = take;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_gap_q  <= fasr_pkg::IDLE_GAP_RST;
			err_ofs_q   <= fasr_pkg::ERR_OFS_RST;
			step_max_q  <= fasr_pkg::STEP_MAX_RST;
			delay_max_q <= fasr_pkg::DELAY_MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				fasr_pkg::CFG_IDLE_GAP:  idle_gap_q  <= cfg_data[7:0];
				fasr_pkg::CFG_ERR_OFS:   err_ofs_q   <= cfg_data[7:0];
				fasr_pkg::CFG_STEP_MAX:  step_max_q  <= cfg_data[6:0];
				fasr_pkg::CFG_DELAY_MAX: delay_max_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the input register whenever the held item resolves or none is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			action_s1   <= action;
			rx_byte_s1  <= rx_byte;
			rx_error_s1 <= rx_error;
		end
	end

	fasr_frame #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.action   (action_s1),
		.rx_byte  (rx_byte_s1),
		.rx_error (rx_error_s1),
		.idle_gap (idle_gap_q),
		.sync     (sync)
	);

	fasr_chan #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_chan (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (go && sync.hit),
		.sync      (sync),
		.rx_byte   (rx_byte_s1),
		.err_ofs   (err_ofs_q),
		.step_max  (step_max_q),
		.delay_max (delay_max_q),
		.res       (res)
	);

	// Load a fresh result, otherwise drop the old one once it transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && sync.hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && sync.hit) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign channel      = out_q.channel;
	assign delay_value  = out_q.delay_value;
	assign step_size    = out_q.step_size;
	assign direction_up = out_q.direction_up;

	a_hit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		go && sync.hit |=> out_valid_q)
		else $error("channel result not loaded");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && sync.hit |-> sync.ch <= fasr_pkg::CH_NUM_W'(NUM_CHANNELS - 1))
		else $error("channel index beyond channel count");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && sync.hit && out_valid_q && !out_ready |-> !in_ready)
		else $error("input taken while result slot blocked");

	a_out_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.delay_value != 15'd0 && out_q.step_size != 7'd0)
		else $error("zero delay or step in result");

endmodule

`default_nettype wire
